FILE: design/cubic_bezier_point_eval_top_macros.svh
// assertion macros for the cubic bezier point evaluator
`ifndef CUBIC_BEZIER_POINT_EVAL_TOP_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CBPE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cbpe assertion failed");

`define CBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbpe assertion failed");

`else

`define CBPE_ASSERT(lbl, clk, rst, prop)

`define CBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/cbpe_pkg.sv
// shared constants for the cubic bezier point evaluator
package cbpe_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int T_WIDTH             = 17;
  localparam int FRAC_SHIFT          = 16;
  localparam int FRAC_HALF           = 32768;
  localparam int AXIS_LATENCY        = 7;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int NUM_POINTS          = 4;
  localparam int NUM_AXES            = 3;

  localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(65536);

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CP0 = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CP1 = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CP2 = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CP3 = CFG_INDEX_WIDTH'(3);

endpackage

FILE: design/cbpe_axis.sv
// one coordinate axis: coefficient setup and pipelined horner evaluation
module cbpe_axis #(
  parameter int COORD_WIDTH = cbpe_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic signed [COORD_WIDTH-1:0]    p0,
  input  logic signed [COORD_WIDTH-1:0]    p1,
  input  logic signed [COORD_WIDTH-1:0]    p2,
  input  logic signed [COORD_WIDTH-1:0]    p3,
  input  logic [cbpe_pkg::T_WIDTH-1:0]     t_in,
  output logic signed [COORD_WIDTH-1:0]    coord
);
  import cbpe_pkg::*;

  localparam int CW = COORD_WIDTH + 4;
  localparam int TW = T_WIDTH + 1;
  localparam int HW = CW + TW;
  localparam int PW = HW + TW;
  localparam int RW = HW - FRAC_SHIFT;
  localparam int XW = HW - CW - FRAC_SHIFT;

  localparam logic signed [PW-1:0] HALF_P = PW'(FRAC_HALF);
  localparam logic signed [HW-1:0] HALF_H = HW'(FRAC_HALF);

  logic signed [CW-1:0] e0, e1, e2, e3;
  logic signed [CW-1:0] d12, s012;
  logic signed [CW-1:0] a_next, b_next, c_next;
  logic signed [CW-1:0] a_q, b_q, c_q, d_q;

  logic signed [TW-1:0] ts0, t1, t2, t3, t4;
  logic signed [HW-1:0] m1, h1, h2, h3;
  logic signed [PW-1:0] m2, m3;
  logic signed [PW-1:0] sum2, sum3;
  logic signed [HW-1:0] sum4;
  logic signed [HW-1:0] b_s, c_s, d_s;
  logic signed [RW-1:0] r4;
  logic [RW-COORD_WIDTH:0] r4_top;
  logic signed [COORD_WIDTH-1:0] coord_next;

  // power basis coefficients
  assign e0   = $signed({{4{p0[COORD_WIDTH-1]}}, p0});
  assign e1   = $signed({{4{p1[COORD_WIDTH-1]}}, p1});
  assign e2   = $signed({{4{p2[COORD_WIDTH-1]}}, p2});
  assign e3   = $signed({{4{p3[COORD_WIDTH-1]}}, p3});
  assign d12  = e1 - e2;
  assign s012 = e0 - (e1 <<< 1) + e2;
  assign a_next = (e3 - e0) + (d12 <<< 1) + d12;
  assign b_next = (s012 <<< 1) + s012;
  assign c_next = ((e1 - e0) <<< 1) + (e1 - e0);

  assign ts0 = $signed({1'b0, t_in});

  assign b_s = $signed({{XW{b_q[CW-1]}}, b_q, {FRAC_SHIFT{1'b0}}});
  assign c_s = $signed({{XW{c_q[CW-1]}}, c_q, {FRAC_SHIFT{1'b0}}});
  assign d_s = $signed({{XW{d_q[CW-1]}}, d_q, {FRAC_SHIFT{1'b0}}});

  assign sum2 = m2 + HALF_P;
  assign sum3 = m3 + HALF_P;
  assign sum4 = h3 + HALF_H;
  assign r4   = sum4[HW-1:FRAC_SHIFT];
  assign r4_top = r4[RW-1:COORD_WIDTH-1];

  // saturate to the coordinate range
  always_comb begin
    if ((&r4_top) || !(|r4_top)) begin
      coord_next = r4[COORD_WIDTH-1:0];
    end else if (r4[RW-1]) begin
      coord_next = $signed({1'b1, {(COORD_WIDTH-1){1'b0}}});
    end else begin
      coord_next = $signed({1'b0, {(COORD_WIDTH-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    a_q   <= a_next;
    b_q   <= b_next;
    c_q   <= c_next;
    d_q   <= e0;
    // horner stages
    m1    <= a_q * ts0;
    t1    <= ts0;
    h1    <= m1 + b_s;
    t2    <= t1;
    m2    <= h1 * t2;
    t3    <= t2;
    h2    <= sum2[HW+FRAC_SHIFT-1:FRAC_SHIFT] + c_s;
    t4    <= t3;
    m3    <= h2 * t4;
    h3    <= sum3[HW+FRAC_SHIFT-1:FRAC_SHIFT] + d_s;
    coord <= coord_next;
  end

endmodule

FILE: design/cubic_bezier_point_eval_top.sv
// top level of the cubic bezier point evaluator
//
//  channel   handshake                 payload
//  input     start / busy              t_value
//  result    result_valid (strobe)     point_x, point_y, point_z
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one t per cycle while busy is low; each point follows its t through the registers below
// path: one input register for t saturation plus seven horner stages per axis
// busy is high only in the cycle after a reset cycle; config is always ready
// synchronous reset clears the control points and the valid line
// results are strobed for one cycle and cannot be held off
`include "cubic_bezier_point_eval_top_macros.svh"

module cubic_bezier_point_eval_top #(
  parameter int COORD_WIDTH = cbpe_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [cbpe_pkg::T_WIDTH-1:0]           t_value,
  output logic                                   result_valid,
  output logic signed [COORD_WIDTH-1:0]          point_x,
  output logic signed [COORD_WIDTH-1:0]          point_y,
  output logic signed [COORD_WIDTH-1:0]          point_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cbpe_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [3*COORD_WIDTH-1:0]               cfg_data
);
  import cbpe_pkg::*;

  localparam int LATENCY = AXIS_LATENCY + 1;
  localparam int PW = NUM_AXES * COORD_WIDTH;

  logic [PW-1:0]          cp [NUM_POINTS];
  logic [LATENCY-1:0]     vld;
  logic [T_WIDTH-1:0]     t_q;
  logic                   accept;
  logic                   cfg_write;
  logic signed [COORD_WIDTH-1:0] coord [NUM_AXES];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        cp[i] <= '0;
      end
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LATENCY-2:0], accept};
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CP0: cp[0] <= cfg_data;
          CFG_CP1: cp[1] <= cfg_data;
          CFG_CP2: cp[2] <= cfg_data;
          CFG_CP3: cp[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // t above one saturates to one
  always_ff @(posedge clk) begin
    t_q <= (t_value > T_ONE) ? T_ONE : t_value;
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    cbpe_axis #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_axis (
      .clk   (clk),
      .p0    ($signed(cp[0][k*COORD_WIDTH +: COORD_WIDTH])),
      .p1    ($signed(cp[1][k*COORD_WIDTH +: COORD_WIDTH])),
      .p2    ($signed(cp[2][k*COORD_WIDTH +: COORD_WIDTH])),
      .p3    ($signed(cp[3][k*COORD_WIDTH +: COORD_WIDTH])),
      .t_in  (t_q),
      .coord (coord[k])
    );
  end

  assign result_valid = vld[LATENCY-1];
  assign point_x      = coord[0];
  assign point_y      = coord[1];
  assign point_z      = coord[2];

  `CBPE_ASSERT(a_result_latency, clk, rst, accept |-> ##LATENCY result_valid)
  `CBPE_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_write && cfg_index == CFG_CP3, cp[3] == $past(cfg_data))
  `CBPE_ASSERT_NEXT(a_busy_clears, clk, rst, 1'b1, !busy)

endmodule

FILE: verif/cubic_bezier_point_eval_top_tb.sv
// testbench for the cubic bezier point evaluator: directed and random t against a local model
module cubic_bezier_point_eval_top_tb;
  import cbpe_pkg::*;

  localparam int W = COORD_WIDTH_DEFAULT;
  localparam int CP_WIDTH = 3 * W;
  localparam int LIMIT_CYCLES = 400000;
  localparam longint T_FULL = longint'(T_ONE);
  localparam longint COORD_HI = (longint'(1) << (W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic [W-1:0] C_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] C_MIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LO = CFG_CP3 + 1'b1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_HI = '1;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } curve_point_t;

  typedef struct packed {
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CP_WIDTH-1:0]        data;
  } cp_write_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [T_WIDTH-1:0]          t_value = '0;
  logic                        result_valid;
  logic signed [W-1:0]         point_x;
  logic signed [W-1:0]         point_y;
  logic signed [W-1:0]         point_z;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
  logic [CP_WIDTH-1:0]         cfg_data = '0;

  logic [CP_WIDTH-1:0] cp_shadow [NUM_POINTS];
  logic [T_WIDTH-1:0]  t_pending [$];
  cp_write_t           cp_pending [$];
  curve_point_t        point_expect [$];

  int  t_gap = 0;
  int  cfg_gap = 0;
  bit  burst_mode = 1'b0;
  int  error_count = 0;
  int  items_taken = 0;
  int  items_queued = 0;
  int  t_over_one = 0;
  int  points_checked = 0;
  int  curve_count = 0;
  int  cycle_count = 0;

  cubic_bezier_point_eval_top #(
    .COORD_WIDTH (W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .t_value      (t_value),
    .result_valid (result_valid),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint coord_of(input logic [CP_WIDTH-1:0] cp_word, input int axis);
    logic signed [W-1:0] c;
    c = cp_word[axis*W +: W];
    return longint'(c);
  endfunction

  function automatic longint round16(input longint v);
    return (v + FRAC_HALF) >>> FRAC_SHIFT;
  endfunction

  function automatic logic [W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) v = COORD_HI;
    if (v < COORD_LO) v = COORD_LO;
    return v[W-1:0];
  endfunction

  function automatic curve_point_t eval_curve(input logic [T_WIDTH-1:0] t_raw);
    curve_point_t pt;
    logic [W-1:0] coord [NUM_AXES];
    longint t, p0, p1, p2, p3, ca, cb, cc, cd, h;
    t = (t_raw > T_ONE) ? T_FULL : longint'(t_raw);
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      p0 = coord_of(cp_shadow[CFG_CP0], axis);
      p1 = coord_of(cp_shadow[CFG_CP1], axis);
      p2 = coord_of(cp_shadow[CFG_CP2], axis);
      p3 = coord_of(cp_shadow[CFG_CP3], axis);
      ca = -p0 + 3 * p1 - 3 * p2 + p3;
      cb = 3 * p0 - 6 * p1 + 3 * p2;
      cc = -3 * p0 + 3 * p1;
      cd = p0;
      h = ca * t + cb * T_FULL;
      h = round16(h * t) + cc * T_FULL;
      h = round16(h * t) + cd * T_FULL;
      coord[axis] = clamp_coord(round16(h));
    end
    pt.x = coord[0];
    pt.y = coord[1];
    pt.z = coord[2];
    return pt;
  endfunction

  function automatic int rand_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [T_WIDTH-1:0] rand_t();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return T_WIDTH'($urandom_range(0, 65536));
    if (r < 68) return T_WIDTH'($urandom_range(0, 15));
    if (r < 80) return T_WIDTH'($urandom_range(65520, 65536));
    if (r < 92) return T_WIDTH'($urandom_range(65537, 131071));
    if (r < 96) return '0;
    return T_ONE;
  endfunction

  function automatic logic [W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return W'($urandom());
    if (r < 60) return W'($urandom_range(0, 1023) - 512);
    if (r < 68) return C_MAX;
    if (r < 76) return C_MIN;
    return W'($urandom_range(0, 16383) - 8192);
  endfunction

  function automatic logic [CP_WIDTH-1:0] rand_cp();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // driver: t items and control point writes
  always @(posedge clk) begin
    cp_write_t w;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      t_gap     <= 0;
      cfg_gap   <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= CFG_CP3) cp_shadow[cfg_index] = cfg_data;
      if (start && !busy) begin
        point_expect.insert(point_expect.size(), eval_curve(t_value));
        items_taken++;
        if (t_value > T_ONE) t_over_one++;
      end
      if (!(start && busy)) begin
        if (t_gap != 0) begin
          start <= 1'b0;
          t_gap <= t_gap - 1;
        end else if (t_pending.size() != 0) begin
          start   <= 1'b1;
          t_value <= t_pending.pop_front();
          t_gap   <= rand_gap();
        end else begin
          start <= 1'b0;
        end
      end
      if (!(cfg_valid && !cfg_ready)) begin
        if (cfg_gap != 0) begin
          cfg_valid <= 1'b0;
          cfg_gap   <= cfg_gap - 1;
        end else if (cp_pending.size() != 0) begin
          w = cp_pending.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.index;
          cfg_data  <= w.data;
          cfg_gap   <= rand_gap();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed point against the oldest prediction
  always @(posedge clk) begin
    curve_point_t want;
    if (!rst && result_valid) begin
      if (point_expect.size() == 0) begin
        report_error($sformatf("unexpected point x=%0d y=%0d z=%0d", point_x, point_y,
                               point_z));
      end else begin
        want = point_expect.pop_front();
        points_checked++;
        if (point_x !== want.x)
          report_error($sformatf("point %0d x: got %0d want %0d", points_checked, point_x,
                                 want.x));
        if (point_y !== want.y)
          report_error($sformatf("point %0d y: got %0d want %0d", points_checked, point_y,
                                 want.y));
        if (point_z !== want.z)
          report_error($sformatf("point %0d z: got %0d want %0d", points_checked, point_z,
                                 want.z));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("cubic_bezier_point_eval_top_tb failed");
      $finish;
    end
  end

  task automatic add_t(input logic [T_WIDTH-1:0] t_in);
    t_pending.insert(t_pending.size(), t_in);
    items_queued++;
  endtask

  task automatic add_cp(input cp_write_t w);
    cp_pending.insert(cp_pending.size(), w);
  endtask

  task automatic load_curve(input logic [CP_WIDTH-1:0] c0, input logic [CP_WIDTH-1:0] c1,
                            input logic [CP_WIDTH-1:0] c2, input logic [CP_WIDTH-1:0] c3);
    cp_write_t w;
    w.index = CFG_INDEX_WIDTH'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI));
    w.data  = rand_cp();
    add_cp(w);
    w.index = CFG_CP0; w.data = c0; add_cp(w);
    w.index = CFG_CP1; w.data = c1; add_cp(w);
    w.index = CFG_CP2; w.data = c2; add_cp(w);
    w.index = CFG_CP3; w.data = c3; add_cp(w);
    while (cp_pending.size() != 0 || cfg_valid) @(posedge clk);
    @(posedge clk);
    curve_count++;
  endtask

  // wait until every queued t has come back as a checked point
  task automatic drain();
    while (points_checked != items_queued) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) add_t(rand_t());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // control points still at their reset value
    add_t('0);
    add_t(T_ONE);
    add_t('1);
    add_t(T_WIDTH'(32768));
    drain();

    // directed t sweep on a plain curve
    load_curve({16'h0000, 16'h0100, 16'hFF00}, {16'h0080, 16'h0400, 16'h0200},
               {16'hFE00, 16'hFC00, 16'h0300}, {16'h0100, 16'h0000, 16'h0500});
    add_t('0);
    add_t(T_WIDTH'(32768));
    add_t(T_WIDTH'(65535));
    add_t(T_ONE);
    add_t(T_ONE + 1'b1);
    add_t('1);
    for (int k = 0; k < T_WIDTH; k++) add_t(T_WIDTH'(1) << k);
    drain();

    // extreme control points, including curves that overflow and saturate
    burst_mode = 1'b1;
    load_curve({3{C_MAX}}, {3{C_MAX}}, {3{C_MAX}}, {3{C_MAX}});
    run_random(30);
    burst_mode = 1'b0;
    load_curve({3{C_MIN}}, {3{C_MIN}}, {3{C_MIN}}, {3{C_MIN}});
    run_random(30);
    load_curve({3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}});
    run_random(30);
    load_curve({3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}});
    run_random(30);

    for (int p = 0; p < 9; p++) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      load_curve(rand_cp(), rand_cp(), rand_cp(), rand_cp());
      run_random(100);
    end

    repeat (AXIS_LATENCY + 4) @(posedge clk);
    if (point_expect.size() != 0)
      report_error($sformatf("%0d points never arrived", point_expect.size()));
    $display("%0d t values taken (%0d above one), %0d points checked", items_taken,
             t_over_one, points_checked);
    $display("%0d control point settings, with extreme and saturating curves", curve_count);
    if (error_count == 0) begin
      $display("cubic_bezier_point_eval_top_tb passed");
    end else begin
      $display("cubic_bezier_point_eval_top_tb failed");
    end
    $finish;
  end

endmodule
